/* rtl/sexpr_pkg.sv */
// shared types, constants and byte codes for the s-expression item counter
// no dependencies; imported by the interfaces and all rtl modules
package sexpr_pkg;

    localparam int CH_W    = 8;
    localparam int DEPTH_W = 8;
    localparam int COUNT_W = 16;

    // saturation limits for nesting depth and item count
    localparam logic [DEPTH_W-1:0] DEPTH_CAP = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_CAP = 16'd65535;

    // byte codes that the tokenizer looks at
    localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_BAR    = 8'h7C;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_VT     = 8'h0B;
    localparam logic [CH_W-1:0] CH_FF     = 8'h0C;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        CLS_WORD    = 3'd0,
        CLS_OPEN    = 3'd1,
        CLS_CLOSE   = 3'd2,
        CLS_SPACE   = 3'd3,
        CLS_SEP     = 3'd4,
        CLS_COMMENT = 3'd5
    } char_class_t;

    // tokenizer state carried from byte to byte
    typedef struct packed {
        logic               comment_mode;
        logic [DEPTH_W-1:0] nest_depth;
        logic               word_nonblank;
        logic [COUNT_W-1:0] top_count;
        logic               sat_flag;
    } tok_state_t;

    // one result item
    typedef struct packed {
        logic [2:0]         char_class;
        logic [DEPTH_W-1:0] depth;
        logic               in_comment;
        logic [COUNT_W-1:0] item_count;
        logic               done_res;
        logic               overflow;
    } tok_result_t;

    function automatic logic is_blank(input logic [CH_W-1:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

/* rtl/sexpr_ifs.sv */
// valid/ready channel interfaces for source bytes and result items
// depends on sexpr_pkg
interface sexpr_byte_if
    import sexpr_pkg::*;
    ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;
    logic            last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface sexpr_result_if
    import sexpr_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [2:0]         char_class;
    logic [DEPTH_W-1:0] depth;
    logic               in_comment;
    logic [COUNT_W-1:0] item_count;
    logic               done_res;
    logic               overflow;

    modport source (output valid, output char_class, output depth, output in_comment,
                    output item_count, output done_res, output overflow, input ready);
    modport sink   (input valid, input char_class, input depth, input in_comment,
                    input item_count, input done_res, input overflow, output ready);
endinterface

/* rtl/sexpr_step.sv */
// per-byte tokenizer update: next state and result for one source byte
// depends on sexpr_pkg
module sexpr_step
    import sexpr_pkg::*;
(
    input  tok_state_t  cur,
    input  logic [CH_W-1:0] ch,
    input  logic        last,
    output tok_state_t  nxt,
    output tok_result_t res
);

    logic        bump;
    logic        deepen;
    logic [2:0]  cls;
    tok_state_t  upd;

    always_comb
    begin
        upd    = cur;
        bump   = 1'b0;
        deepen = 1'b0;
        cls    = CLS_WORD;
        if (cur.comment_mode)
        begin
            cls = CLS_COMMENT;
            if (ch == CH_NL)
            begin
                upd.comment_mode = 1'b0;
                bump = (cur.nest_depth == '0);
            end
        end
        else if (ch == CH_SEMI)
        begin
            cls = CLS_COMMENT;
            upd.comment_mode  = 1'b1;
            upd.word_nonblank = 1'b0;
        end
        else if (ch == CH_LPAREN)
        begin
            cls = CLS_OPEN;
            upd.word_nonblank = 1'b0;
            bump   = (cur.nest_depth == '0);
            deepen = 1'b1;
        end
        else if (ch == CH_RPAREN)
        begin
            cls = CLS_CLOSE;
            upd.word_nonblank = 1'b0;
            if (cur.nest_depth == '0)
                bump = 1'b1;
            else
                upd.nest_depth = cur.nest_depth - 1'b1;
        end
        else if ((ch == CH_SPACE) || (ch == CH_NL))
        begin
            cls = CLS_SPACE;
            upd.word_nonblank = 1'b0;
        end
        else if ((ch == CH_COMMA) || (ch == CH_BAR))
        begin
            cls = CLS_SEP;
            upd.word_nonblank = 1'b0;
            bump = (cur.nest_depth == '0);
        end
        else if (!is_blank(ch) && !cur.word_nonblank)
        begin
            upd.word_nonblank = 1'b1;
            bump = (cur.nest_depth == '0);
        end

        // counter and depth saturate instead of wrapping
        if (bump)
        begin
            if (cur.top_count == COUNT_CAP)
                upd.sat_flag = 1'b1;
            else
                upd.top_count = cur.top_count + 1'b1;
        end
        if (deepen)
        begin
            if (cur.nest_depth == DEPTH_CAP)
                upd.sat_flag = 1'b1;
            else
                upd.nest_depth = cur.nest_depth + 1'b1;
        end

        res.char_class = cls;
        res.depth      = upd.nest_depth;
        res.in_comment = upd.comment_mode;
        res.item_count = upd.top_count;
        res.done_res   = last;
        res.overflow   = upd.sat_flag;

        // end of text returns the tokenizer to its reset state
        nxt = last ? tok_state_t'('0) : upd;
    end

endmodule

/* rtl/sexpr_top_level_counter.sv */
// s-expression tokenizer and top-level item counter, one byte per request
// a result is registered and appears in the cycle after its byte is accepted
// throughput: one byte per cycle while the sink takes results, limited only by the single result register
// reset (rst_n, async, active low) clears the tokenizer state and the result valid
// state also returns to reset after a byte marked last
// depends on sexpr_pkg, sexpr_ifs, sexpr_step
module sexpr_top_level_counter
    import sexpr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    sexpr_byte_if.sink     byte_in,
    sexpr_result_if.source result
);

    tok_state_t  state_reg;
    tok_state_t  state_next;
    tok_result_t res_reg;
    tok_result_t res_next;
    logic        res_valid_reg;
    logic        accept;

    // the result register frees up in the same cycle it is taken downstream,
    // so a new byte request is taken every cycle while the sink keeps up
    assign byte_in.ready = !res_valid_reg || result.ready;
    assign accept        = byte_in.valid && byte_in.ready;

    // whole per-byte update is one short combinational step
    sexpr_step u_step (
        .cur  (state_reg),
        .ch   (byte_in.ch),
        .last (byte_in.last),
        .nxt  (state_next),
        .res  (res_next)
    );

    // tokenizer state advances only on an accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, held while the sink stalls
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.char_class = res_reg.char_class;
    assign result.depth      = res_reg.depth;
    assign result.in_comment = res_reg.in_comment;
    assign result.item_count = res_reg.item_count;
    assign result.done_res   = res_reg.done_res;
    assign result.overflow   = res_reg.overflow;

endmodule

/* tb/sexpr_top_level_counter_test.sv */
`timescale 1ns / 100ps
// self-checking test of sexpr_top_level_counter: directed, saturating and random source texts
// depends on sexpr_pkg, the channel interfaces in sexpr_ifs and the rtl of the counter
module sexpr_top_level_counter_test;
    import sexpr_pkg::*;

    // one source byte waiting to be offered on the byte channel
    typedef struct {
        logic [CH_W-1:0] ch;
        logic            last;
    } text_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sexpr_byte_if   byte_ch ();
    sexpr_result_if result_ch ();

    sexpr_top_level_counter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .result  (result_ch)
    );

    // bytes still to be sent, and token results owed by the block, oldest first
    text_byte_t  text_bytes[$];
    tok_result_t token_results_due[$];

    // shadow copy of the tokenizer state
    logic               sh_comment;
    logic [DEPTH_W-1:0] sh_depth;
    logic               sh_word_nonblank;
    logic [COUNT_W-1:0] sh_count;
    logic               sh_sat;

    int          error_count  = 0;
    int          results_seen = 0;
    int          send_gap     = 0;
    int          recv_stall   = 0;
    int          recv_hold    = 0;
    bit          send_quiet   = 1'b0;
    bit          recv_quiet   = 1'b0;
    text_byte_t  next_byte;
    tok_result_t want;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow tokenizer
    // ------------------------------------------------------------------

    function automatic void clear_tokenizer();
        sh_comment       = 1'b0;
        sh_depth         = '0;
        sh_word_nonblank = 1'b0;
        sh_count         = '0;
        sh_sat           = 1'b0;
    endfunction

    // a top-level item at the count cap is lost and flags overflow
    function automatic void bump_top_count();
        if (sh_count >= COUNT_CAP)
            sh_sat = 1'b1;
        else
            sh_count = sh_count + 1'b1;
    endfunction

    // advance the shadow state by one byte and return the token result it owes
    function automatic tok_result_t tokenize_byte(logic [CH_W-1:0] c, logic fin);
        tok_result_t r;
        char_class_t cls;
        if (sh_comment)
        begin
            // everything inside a comment is a comment byte; newline closes it
            cls = CLS_COMMENT;
            if (c == CH_NL)
            begin
                sh_comment = 1'b0;
                if (sh_depth == 0)
                    bump_top_count();
            end
        end
        else if (c == CH_SEMI)
        begin
            cls              = CLS_COMMENT;
            sh_comment       = 1'b1;
            sh_word_nonblank = 1'b0;
        end
        else if (c == CH_LPAREN)
        begin
            cls              = CLS_OPEN;
            sh_word_nonblank = 1'b0;
            if (sh_depth == 0)
                bump_top_count();
            // open at the depth cap keeps the depth and flags overflow
            if (sh_depth >= DEPTH_CAP)
                sh_sat = 1'b1;
            else
                sh_depth = sh_depth + 1'b1;
        end
        else if (c == CH_RPAREN)
        begin
            cls              = CLS_CLOSE;
            sh_word_nonblank = 1'b0;
            // a close at depth zero is a stray item of its own
            if (sh_depth == 0)
                bump_top_count();
            else
                sh_depth = sh_depth - 1'b1;
        end
        else if (c == CH_SPACE || c == CH_NL)
        begin
            cls              = CLS_SPACE;
            sh_word_nonblank = 1'b0;
        end
        else if (c == CH_COMMA || c == CH_BAR)
        begin
            cls              = CLS_SEP;
            sh_word_nonblank = 1'b0;
            if (sh_depth == 0)
                bump_top_count();
        end
        else
        begin
            // word byte; tab, cr, vt and ff stay in the word but do not make it count
            cls = CLS_WORD;
            if (!(c inside {CH_SPACE, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR}) && !sh_word_nonblank)
            begin
                sh_word_nonblank = 1'b1;
                if (sh_depth == 0)
                    bump_top_count();
            end
        end
        r.char_class = cls;
        r.depth      = sh_depth;
        r.in_comment = sh_comment;
        r.item_count = sh_count;
        r.done_res   = fin;
        r.overflow   = sh_sat;
        // the byte marked last ends the text and the state starts over
        if (fin)
            clear_tokenizer();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // text building
    // ------------------------------------------------------------------

    function automatic void add_byte(logic [CH_W-1:0] c);
        text_byte_t b;
        b.ch   = c;
        b.last = 1'b0;
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    function automatic void mark_last();
        text_bytes[text_bytes.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [CH_W-1:0] pick_comment_byte();
        logic [CH_W-1:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_NL);
        return c;
    endfunction

    // one random text: mostly well-formed tokens, sometimes raw noise,
    // occasionally ending with an open group or an unterminated comment
    task automatic gen_random_text();
        int              open_groups;
        int              pick;
        logic [CH_W-1:0] wb;
        open_groups = 0;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 20))
                add_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(1, 14))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 18 && open_groups < 6)
                begin
                    add_byte(CH_LPAREN);
                    open_groups++;
                end
                else if (pick < 34 && open_groups > 0)
                begin
                    add_byte(CH_RPAREN);
                    open_groups--;
                end
                else if (pick < 56)
                begin
                    // word, sometimes led by a blank that does not count
                    if ($urandom_range(0, 3) == 0)
                    begin
                        case ($urandom_range(0, 3))
                            0: add_byte(CH_TAB);
                            1: add_byte(CH_VT);
                            2: add_byte(CH_FF);
                            default: add_byte(CH_CR);
                        endcase
                    end
                    repeat ($urandom_range(1, 6))
                    begin
                        do
                            wb = 8'($urandom_range(0, 255));
                        while (wb inside {CH_LPAREN, CH_RPAREN, CH_SPACE, CH_SEMI,
                                          CH_COMMA, CH_BAR, CH_NL});
                        add_byte(wb);
                    end
                end
                else if (pick < 68)
                begin
                    case ($urandom_range(0, 2))
                        0: add_byte(CH_SPACE);
                        1: add_byte(CH_NL);
                        default: add_byte(CH_TAB);
                    endcase
                end
                else if (pick < 76)
                    add_byte($urandom_range(0, 1) ? CH_COMMA : CH_BAR);
                else if (pick < 86)
                begin
                    add_byte(CH_SEMI);
                    repeat ($urandom_range(0, 6))
                        add_byte(pick_comment_byte());
                    add_byte(CH_NL);
                end
                else if (pick < 92)
                begin
                    add_byte(CH_RPAREN);
                    if (open_groups > 0)
                        open_groups--;
                end
                else
                    add_byte(8'($urandom_range(0, 255)));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                add_byte(CH_SEMI);
                repeat ($urandom_range(0, 3))
                    add_byte(pick_comment_byte());
            end
            else if (pick > 2)
                repeat (open_groups)
                    add_byte(CH_RPAREN);
        end
        mark_last();
    endtask

    // random idle length: mostly none, some short, a few long
    function automatic int pick_gap(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    task automatic check_field(string field, int want_v, int got_v);
        if (want_v != got_v)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want_v, got_v);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers bytes from the queue, predicts on every accepted request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            byte_ch.valid <= 1'b0;
        else if (!byte_ch.valid || byte_ch.ready)
        begin
            if (byte_ch.valid)
                token_results_due.insert(token_results_due.size(),
                                         tokenize_byte(byte_ch.ch, byte_ch.last));
            // switch now and then between idling and back-to-back sending
            if ($urandom_range(0, 199) == 0)
                send_quiet = !send_quiet;
            if (send_gap > 0)
            begin
                send_gap--;
                byte_ch.valid <= 1'b0;
            end
            else if (text_bytes.size() > 0)
            begin
                next_byte = text_bytes.pop_front();
                byte_ch.valid <= 1'b1;
                byte_ch.ch    <= next_byte.ch;
                byte_ch.last  <= next_byte.last;
                send_gap = pick_gap(send_quiet);
            end
            else
                byte_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each accepted result and paces ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (token_results_due.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: result with none expected, class %0d count %0d",
                             $time, result_ch.char_class, result_ch.item_count);
                end
                else
                begin
                    want = token_results_due.pop_front();
                    check_field("char_class", want.char_class, result_ch.char_class);
                    check_field("depth", want.depth, result_ch.depth);
                    check_field("in_comment", want.in_comment, result_ch.in_comment);
                    check_field("item_count", want.item_count, result_ch.item_count);
                    check_field("done_res", want.done_res, result_ch.done_res);
                    check_field("overflow", want.overflow, result_ch.overflow);
                end
                // long hold-off after the 150th result so the block backs up onto its input
                if (results_seen % 20000 == 150)
                    recv_hold = 100;
            end
            if ($urandom_range(0, 199) == 0)
                recv_quiet = !recv_quiet;
            if (recv_hold > 0)
            begin
                recv_hold--;
                result_ch.ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_stall = pick_gap(recv_quiet);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int target;
        byte_ch.valid   = 1'b0;
        byte_ch.ch      = '0;
        byte_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        clear_tokenizer();

        // directed text: field extremes, every class, comments at depth zero and
        // inside a group, stray close, and a group left open at the end
        add_byte(8'h00);        // word with a non-blank first byte
        add_byte(8'hFF);        // same word, no new item
        add_byte(CH_SPACE);
        add_byte(CH_TAB);       // word byte that is blank
        add_byte(8'h78);        // first non-blank byte of that word counts
        add_byte(CH_COMMA);
        add_byte(CH_BAR);
        add_byte(CH_RPAREN);    // stray close
        add_byte(CH_LPAREN);
        add_byte(CH_SEMI);      // comment inside the group
        add_byte(CH_LPAREN);
        add_byte(CH_RPAREN);
        add_byte(CH_SEMI);
        add_byte(CH_NL);        // ends it, not counted at depth one
        add_byte(8'h62);        // nested word, not counted
        add_byte(CH_RPAREN);
        add_byte(CH_NL);        // plain newline is a space
        add_byte(CH_SEMI);
        add_byte(8'h7A);
        add_byte(CH_NL);        // top-level comment counted here
        add_byte(CH_LPAREN);    // unclosed group, counted once
        mark_last();

        // unterminated comment at the end is dropped
        add_byte(CH_SEMI);
        add_byte(8'h71);
        mark_last();

        // depth saturation: one open past the cap, then a few closes
        repeat (256)
            add_byte(CH_LPAREN);
        repeat (3)
            add_byte(CH_RPAREN);
        add_byte(8'h77);
        add_byte(CH_RPAREN);
        mark_last();

        // random texts up to the total byte budget
        target = 1650;
        while (text_bytes.size() < target)
            gen_random_text();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every byte went in and every result came back
        while (text_bytes.size() != 0 || byte_ch.valid || token_results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/sexpr_pkg.sv
rtl/sexpr_ifs.sv
rtl/sexpr_step.sv
rtl/sexpr_top_level_counter.sv
tb/sexpr_top_level_counter_test.sv
